### hdl/sedir_pkg.sv
// shared types, codes and defaults for the shared/exclusive directory server
// no dependencies; imported by the output stage, the directory server and the bench files
package sedir_pkg;

  localparam int NUM_HANDLES_DEF = 16;
  localparam int NUM_CLIENTS_DEF = 8;

  typedef enum logic [1:0] {
    ST_INV  = 2'd0,
    ST_SHR  = 2'd1,
    ST_EXC  = 2'd2,
    ST_NONE = 2'd3
  } st_code_t;

  typedef enum logic [1:0] {
    OP_UPG = 2'd0,
    OP_DWN = 2'd1,
    OP_CLS = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    K_UPG  = 3'd0,
    K_DWN  = 3'd1,
    K_CLS  = 3'd2,
    K_DONE = 3'd3,
    K_ERR  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRD,
    S_SCMP,
    S_LRD,
    S_LCAP,
    S_APPLY,
    S_CNT,
    S_GRANT,
    S_DOWN,
    S_WB,
    S_FIN
  } fsm_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  dest;
    logic [63:0] handle;
    logic [1:0]  state;
    logic        last;
  } msg_t;

endpackage

### hdl/sedir_ifs.sv
// valid/ready channel interfaces for requests and outgoing messages
// no dependencies
interface sedir_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  client_port;
  logic [63:0] handle_id;
  logic [1:0]  req_state;

  modport source(output valid, opcode, client_port, handle_id, req_state, input ready);
  modport sink(input valid, opcode, client_port, handle_id, req_state, output ready);
endinterface

interface sedir_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  msg_kind;
  logic [2:0]  dest_client;
  logic [63:0] msg_handle;
  logic [1:0]  msg_state;
  logic        last;

  modport source(output valid, msg_kind, dest_client, msg_handle, msg_state, last,
                 input ready);
  modport sink(input valid, msg_kind, dest_client, msg_handle, msg_state, last,
               output ready);
endinterface

### hdl/sedir_out_stage.sv
// output register for outgoing messages, decouples the sequencer from the sink
// depends on sedir_pkg and sedir_out_if
module sedir_out_stage import sedir_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  msg_t         msg,
  output logic         free,
  sedir_out_if.source  out_chan
);

  logic valid_r, valid_nxt;
  msg_t msg_r, msg_nxt;

  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    msg_nxt   = msg_r;
    if (load) begin
      valid_nxt = 1'b1;
      msg_nxt   = msg;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    msg_r <= msg_nxt;
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.msg_kind    = msg_r.kind;
  assign out_chan.dest_client = msg_r.dest;
  assign out_chan.msg_handle  = msg_r.handle;
  assign out_chan.msg_state   = msg_r.state;
  assign out_chan.last        = msg_r.last;

endmodule

### hdl/shared_exclusive_directory_server.sv
// shared/exclusive ownership directory: handle table, client rows and sequencer
// depends on sedir_pkg, sedir_ifs and sedir_out_stage
//
// in_chan takes one client request (upgrade, downgrade confirm, close) when
// valid and ready are high; ready is high only while the sequencer is idle.
// out_chan gives the outgoing messages in order, then one done or error item
// with last set. Results sit in an output register, so the sequencer only
// waits when that register is full and the sink holds ready low.
// A request steps through, as needed: take it, scan the handle-table entries
// (up to NUM_HANDLES, one id memory read each), load the client row, apply,
// count states over the NUM_CLIENTS rows, run the grant and downgrade passes
// over the n clients of the handle in arrival order, write back and give the
// final item; output stalls add waits. Requests with bad fields go straight
// to the final item; an unknown handle or a full table is found after the
// scan. The count and passes go through one sequencer working on a single
// client record per cycle, passes only while the output register is free.
// Reset clears the handle valid bits and the control state; the id and row
// memories need no clearing.
module shared_exclusive_directory_server import sedir_pkg::*; #(
  parameter int NUM_HANDLES = NUM_HANDLES_DEF,
  parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sedir_in_if.sink    in_chan,
  sedir_out_if.source out_chan
);

  localparam int CLW  = $clog2(NUM_CLIENTS);
  localparam int RKW  = CLW;
  localparam int CNW  = $clog2(NUM_CLIENTS + 1);
  localparam int HW   = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
  localparam int RECW = 7 + RKW;
  localparam int ROWW = NUM_CLIENTS * RECW;

  fsm_t state_r, state_nxt;

  logic [1:0]  op_r, op_nxt;
  logic [2:0]  cp_r, cp_nxt;
  logic [63:0] id_r, id_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        err_r, err_nxt;
  logic        new_r, new_nxt;
  logic [HW-1:0] hk_r, hk_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [HW-1:0] fidx_r, fidx_nxt;
  logic          ff_r, ff_nxt;
  logic [NUM_HANDLES-1:0] valid_r, valid_nxt;

  logic [NUM_CLIENTS-1:0] pres_r, pres_nxt;
  logic [1:0]     cur_r [NUM_CLIENTS];
  logic [1:0]     cur_nxt [NUM_CLIENTS];
  logic [1:0]     cw_r [NUM_CLIENTS];
  logic [1:0]     cw_nxt [NUM_CLIENTS];
  logic [1:0]     sw_r [NUM_CLIENTS];
  logic [1:0]     sw_nxt [NUM_CLIENTS];
  logic [RKW-1:0] rank_r [NUM_CLIENTS];
  logic [RKW-1:0] rank_nxt [NUM_CLIENTS];

  logic [CNW-1:0] n_r, n_nxt, nsh_r, nsh_nxt, nex_r, nex_nxt;
  logic [CNW-1:0] wsh_r, wsh_nxt, wex_r, wex_nxt;
  logic [CLW-1:0] ck_r, ck_nxt;
  logic [RKW-1:0] rr_r, rr_nxt;

  // handle id memory and client row memory
  logic [63:0]   id_mem [NUM_HANDLES];
  logic [63:0]   id_q;
  logic          id_we;
  logic [HW-1:0] id_waddr;
  logic [ROWW-1:0] row_mem [NUM_HANDLES];
  logic [ROWW-1:0] row_q, row_wd;
  logic            row_we;

  logic   out_free, emit_v;
  msg_t   emit_msg;

  logic [CLW-1:0] cidx, rd_idx, sel;
  logic           sel_hit, bad_in, match, hk_last, ck_last, rr_last;
  logic           upg_hit, cls_bad, cls_empty;
  logic [CNW-1:0] cnt0, cnt1;
  logic           newc;
  logic [1:0]     cur_c, cw_c, sw_c, rc_cur, rc_cw, rc_sw;
  logic [RKW-1:0] rk_c, rc_rank;

  assign in_chan.ready = (state_r == S_IDLE);
  assign cidx    = CLW'(cp_r);
  assign match   = valid_r[hk_r] && (id_q == id_r);
  assign hk_last = (hk_r == HW'(NUM_HANDLES - 1));
  assign ck_last = (ck_r == CLW'(NUM_CLIENTS - 1));
  assign rr_last = (CNW'(rr_r) == n_r - CNW'(1));

  always_comb begin
    bad_in = 1'b0;
    if (32'(in_chan.client_port) >= 32'(NUM_CLIENTS)) bad_in = 1'b1;
    case (in_chan.opcode)
      OP_UPG:  if (in_chan.req_state != ST_SHR && in_chan.req_state != ST_EXC) bad_in = 1'b1;
      OP_DWN:  if (in_chan.req_state != ST_INV && in_chan.req_state != ST_SHR) bad_in = 1'b1;
      OP_CLS:  if (in_chan.req_state == ST_NONE) bad_in = 1'b1;
      default: bad_in = 1'b1;
    endcase
  end

  // client at the current arrival rank
  always_comb begin
    sel     = '0;
    sel_hit = 1'b0;
    for (int e = 0; e < NUM_CLIENTS; e++) begin
      if (pres_r[e] && rank_r[e] == rr_r) begin
        sel     = CLW'(e);
        sel_hit = 1'b1;
      end
    end
  end

  always_comb begin
    case (state_r)
      S_CNT:             rd_idx = ck_r;
      S_GRANT, S_DOWN:   rd_idx = sel;
      default:           rd_idx = cidx;
    endcase
  end

  assign rc_cur  = cur_r[rd_idx];
  assign rc_cw   = cw_r[rd_idx];
  assign rc_sw   = sw_r[rd_idx];
  assign rc_rank = rank_r[rd_idx];

  always_comb begin
    cnt0 = '0;
    for (int e = 0; e < NUM_CLIENTS; e++) cnt0 = cnt0 + CNW'(pres_r[e]);
  end

  assign newc  = !pres_r[cidx];
  assign cur_c = newc ? ST_INV : rc_cur;
  assign cw_c  = newc ? ST_NONE : rc_cw;
  assign sw_c  = newc ? ST_NONE : rc_sw;
  assign rk_c  = newc ? RKW'(cnt0) : rc_rank;
  assign cnt1  = cnt0 + CNW'(newc);
  assign upg_hit   = (cur_c < st_r);
  assign cls_bad   = !pres_r[cidx];
  assign cls_empty = (cnt0 == CNW'(1));

  always_comb begin
    for (int e = 0; e < NUM_CLIENTS; e++) begin
      row_wd[e*RECW +: RECW] = {pres_r[e], cur_r[e], cw_r[e], sw_r[e], rank_r[e]};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_chan.valid) state_nxt = bad_in ? S_FIN : S_SRD;
      S_SRD:   state_nxt = S_SCMP;
      S_SCMP: begin
        if (match) state_nxt = S_LRD;
        else if (hk_last) state_nxt = (op_r != OP_CLS && ff_r) ? S_LRD : S_FIN;
        else state_nxt = S_SRD;
      end
      S_LRD:   state_nxt = S_LCAP;
      S_LCAP:  state_nxt = S_APPLY;
      S_APPLY: begin
        if (out_free) begin
          case (op_r)
            OP_UPG:  state_nxt = upg_hit ? S_CNT : S_WB;
            OP_DWN:  state_nxt = S_CNT;
            default: state_nxt = cls_bad ? S_FIN : (cls_empty ? S_FIN : S_CNT);
          endcase
        end
      end
      S_CNT:   if (ck_last) state_nxt = S_GRANT;
      S_GRANT: if (out_free && rr_last) state_nxt = S_DOWN;
      S_DOWN:  if (out_free && rr_last) state_nxt = S_WB;
      S_WB:    state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt = op_r; cp_nxt = cp_r; id_nxt = id_r; st_nxt = st_r;
    err_nxt = err_r; new_nxt = new_r; hk_nxt = hk_r; h_nxt = h_r;
    fidx_nxt = fidx_r; ff_nxt = ff_r; valid_nxt = valid_r;
    pres_nxt = pres_r; cur_nxt = cur_r; cw_nxt = cw_r; sw_nxt = sw_r; rank_nxt = rank_r;
    n_nxt = n_r; nsh_nxt = nsh_r; nex_nxt = nex_r; wsh_nxt = wsh_r; wex_nxt = wex_r;
    ck_nxt = ck_r; rr_nxt = rr_r;
    id_we = 1'b0; id_waddr = fidx_r; row_we = 1'b0;
    emit_v = 1'b0;
    emit_msg = '{kind: K_DONE, dest: cp_r, handle: id_r, state: 2'd0, last: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt  = in_chan.opcode;
          cp_nxt  = in_chan.client_port;
          id_nxt  = in_chan.handle_id;
          st_nxt  = in_chan.req_state;
          err_nxt = bad_in;
          new_nxt = 1'b0;
          hk_nxt  = '0;
          ff_nxt  = 1'b0;
        end
      end
      S_SRD: begin
        if (!ff_r && !valid_r[hk_r]) begin
          ff_nxt   = 1'b1;
          fidx_nxt = hk_r;
        end
      end
      S_SCMP: begin
        if (match) begin
          h_nxt = hk_r;
        end else if (hk_last) begin
          if (op_r != OP_CLS && ff_r) begin
            valid_nxt[fidx_r] = 1'b1;
            id_we   = 1'b1;
            h_nxt   = fidx_r;
            new_nxt = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end else begin
          hk_nxt = hk_r + HW'(1);
        end
      end
      S_LCAP: begin
        for (int e = 0; e < NUM_CLIENTS; e++) begin
          pres_nxt[e] = new_r ? 1'b0 : row_q[e*RECW + RECW - 1];
          cur_nxt[e]  = row_q[e*RECW + RECW - 2 -: 2];
          cw_nxt[e]   = row_q[e*RECW + RECW - 4 -: 2];
          sw_nxt[e]   = row_q[e*RECW + RECW - 6 -: 2];
          rank_nxt[e] = row_q[e*RECW +: RKW];
        end
      end
      S_APPLY: begin
        if (out_free) begin
          nsh_nxt = '0; nex_nxt = '0; wsh_nxt = '0; wex_nxt = '0;
          ck_nxt  = '0;
          rr_nxt  = '0;
          case (op_r)
            OP_UPG: begin
              pres_nxt[cidx] = 1'b1;
              cur_nxt[cidx]  = upg_hit ? ST_INV : cur_c;
              cw_nxt[cidx]   = upg_hit ? st_r : cw_c;
              sw_nxt[cidx]   = sw_c;
              rank_nxt[cidx] = upg_hit ? RKW'(cnt1 - CNW'(1)) : rk_c;
              if (upg_hit) begin
                for (int e = 0; e < NUM_CLIENTS; e++) begin
                  if (CLW'(e) != cidx && pres_r[e] && rank_r[e] > rk_c)
                    rank_nxt[e] = rank_r[e] - RKW'(1);
                end
              end
              n_nxt = cnt1;
            end
            OP_DWN: begin
              pres_nxt[cidx] = 1'b1;
              cur_nxt[cidx]  = st_r;
              cw_nxt[cidx]   = cw_c;
              sw_nxt[cidx]   = (st_r <= sw_c) ? ST_NONE : sw_c;
              rank_nxt[cidx] = rk_c;
              n_nxt = cnt1;
            end
            default: begin
              if (cls_bad) begin
                err_nxt = 1'b1;
              end else begin
                emit_v = 1'b1;
                emit_msg.kind  = K_CLS;
                emit_msg.state = ST_NONE;
                pres_nxt[cidx] = 1'b0;
                for (int e = 0; e < NUM_CLIENTS; e++) begin
                  if (pres_r[e] && rank_r[e] > rc_rank)
                    rank_nxt[e] = rank_r[e] - RKW'(1);
                end
                n_nxt = cnt0 - CNW'(1);
                if (cls_empty) valid_nxt[h_r] = 1'b0;
              end
            end
          endcase
        end
      end
      S_CNT: begin
        if (pres_r[ck_r]) begin
          if (rc_cur == ST_SHR) nsh_nxt = nsh_r + CNW'(1);
          if (rc_cur == ST_EXC) nex_nxt = nex_r + CNW'(1);
          if (rc_cw == ST_SHR)  wsh_nxt = wsh_r + CNW'(1);
          if (rc_cw == ST_EXC)  wex_nxt = wex_r + CNW'(1);
        end
        ck_nxt = ck_r + CLW'(1);
      end
      S_GRANT: begin
        if (out_free) begin
          rr_nxt = rr_last ? '0 : rr_r + RKW'(1);
          emit_msg.dest = 3'(sel);
          if (sel_hit) begin
            if (rc_cw == ST_SHR && nex_r == '0) begin
              emit_v = 1'b1;
              emit_msg.kind  = K_UPG;
              emit_msg.state = ST_SHR;
              cur_nxt[sel] = ST_SHR;
              cw_nxt[sel]  = ST_NONE;
              wsh_nxt = wsh_r - CNW'(1);
              nsh_nxt = nsh_r + CNW'(1);
            end else if (rc_cw == ST_EXC && nex_r == '0 && nsh_r == '0) begin
              emit_v = 1'b1;
              emit_msg.kind  = K_UPG;
              emit_msg.state = ST_EXC;
              cur_nxt[sel] = ST_EXC;
              cw_nxt[sel]  = ST_NONE;
              wex_nxt = wex_r - CNW'(1);
              nex_nxt = nex_r + CNW'(1);
            end else if (rc_cw == ST_EXC && nex_r == '0 && nsh_r == CNW'(1)
                         && rc_cur == ST_SHR) begin
              emit_v = 1'b1;
              emit_msg.kind  = K_UPG;
              emit_msg.state = ST_EXC;
              cur_nxt[sel] = ST_EXC;
              cw_nxt[sel]  = ST_NONE;
              wex_nxt = wex_r - CNW'(1);
              nex_nxt = nex_r + CNW'(1);
              nsh_nxt = nsh_r - CNW'(1);
            end
          end
        end
      end
      S_DOWN: begin
        if (out_free) begin
          rr_nxt = rr_r + RKW'(1);
          emit_msg.dest = 3'(sel);
          emit_msg.kind = K_DWN;
          if (sel_hit) begin
            if (wex_r != '0) begin
              if ((rc_cur == ST_SHR || rc_cur == ST_EXC) && rc_sw != ST_INV) begin
                emit_v = 1'b1;
                emit_msg.state = ST_INV;
                sw_nxt[sel] = ST_INV;
              end
            end else if (wsh_r != '0) begin
              if (rc_cur == ST_EXC && rc_sw != ST_SHR && rc_sw != ST_INV) begin
                emit_v = 1'b1;
                emit_msg.state = ST_SHR;
                sw_nxt[sel] = ST_SHR;
              end
            end
          end
        end
      end
      S_WB: row_we = 1'b1;
      S_FIN: begin
        if (out_free) begin
          emit_v = 1'b1;
          emit_msg.kind = err_r ? K_ERR : K_DONE;
          emit_msg.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    op_r <= op_nxt; cp_r <= cp_nxt; id_r <= id_nxt; st_r <= st_nxt;
    err_r <= err_nxt; new_r <= new_nxt; hk_r <= hk_nxt; h_r <= h_nxt;
    fidx_r <= fidx_nxt; ff_r <= ff_nxt;
    pres_r <= pres_nxt; cur_r <= cur_nxt; cw_r <= cw_nxt; sw_r <= sw_nxt;
    rank_r <= rank_nxt;
    n_r <= n_nxt; nsh_r <= nsh_nxt; nex_r <= nex_nxt; wsh_r <= wsh_nxt; wex_r <= wex_nxt;
    ck_r <= ck_nxt; rr_r <= rr_nxt;
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_waddr] <= id_r;
    id_q <= id_mem[hk_r];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[h_r] <= row_wd;
    row_q <= row_mem[h_r];
  end

  sedir_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (emit_v),
    .msg      (emit_msg),
    .free     (out_free),
    .out_chan (out_chan)
  );

endmodule

### bench/tb_sedir_ifs.sv
// bench-side copies are not needed; this file holds the bench helpers
// for the directory server bench: request record type shared by driver and stimulus
// depends on sedir_pkg
package tb_sedir_pkg;
  import sedir_pkg::*;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  client_port;
    logic [63:0] handle_id;
    logic [1:0]  req_state;
  } req_t;
endpackage

### bench/tb_shared_exclusive_directory_server.sv
// bench for the shared/exclusive directory server: random and directed requests,
// behavioral directory predictor, in-order message check; depends on sedir_pkg,
// sedir_ifs and tb_sedir_pkg
module tb_shared_exclusive_directory_server;
  timeunit 1ns;
  timeprecision 1ps;
  import sedir_pkg::*;
  import tb_sedir_pkg::*;

  localparam int NH = NUM_HANDLES_DEF;
  localparam int NC = NUM_CLIENTS_DEF;
  localparam int SL = NH * NC;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sedir_in_if in_chan();
  sedir_out_if out_chan();

  shared_exclusive_directory_server u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directory image
  bit          dir_valid [NH];
  logic [63:0] dir_id [NH];
  bit          cl_present [SL];
  st_code_t    cl_cur [SL];
  st_code_t    cl_want [SL];
  st_code_t    srv_want [SL];
  int          cl_rank [SL];

  req_t pending_reqs[$];
  msg_t expected_msgs[$];
  int   fails = 0;
  int   cycles = 0;
  bit   stim_done = 1'b0;
  logic [63:0] id_pool [6];

  function automatic void push_msg(kind_t k, int d, logic [63:0] h, logic [1:0] s, bit l);
    msg_t m;
    m.kind = k; m.dest = d[2:0]; m.handle = h; m.state = s; m.last = l;
    expected_msgs.push_back(m);
  endfunction

  function automatic int clients_of(int h);
    int n = 0;
    for (int c = 0; c < NC; c++) if (cl_present[h*NC+c]) n++;
    return n;
  endfunction

  function automatic int client_at(int h, int r);
    for (int c = 0; c < NC; c++)
      if (cl_present[h*NC+c] && cl_rank[h*NC+c] == r) return c;
    return -1;
  endfunction

  function automatic void shift_ranks(int h, int old);
    for (int c = 0; c < NC; c++)
      if (cl_present[h*NC+c] && cl_rank[h*NC+c] > old) cl_rank[h*NC+c]--;
  endfunction

  function automatic void arbitrate(int h);
    int n_sh = 0, n_ex = 0, w_sh = 0, w_ex = 0, c, s;
    int n;
    logic [63:0] hid;
    n = clients_of(h);
    hid = dir_id[h];
    for (int i = 0; i < NC; i++) begin
      s = h*NC+i;
      if (cl_present[s]) begin
        if (cl_cur[s] == ST_SHR) n_sh++;
        if (cl_cur[s] == ST_EXC) n_ex++;
        if (cl_want[s] == ST_SHR) w_sh++;
        if (cl_want[s] == ST_EXC) w_ex++;
      end
    end
    for (int r = 0; r < n; r++) begin
      c = client_at(h, r);
      if (c >= 0) begin
        s = h*NC+c;
        if (cl_want[s] == ST_SHR && n_ex == 0) begin
          push_msg(K_UPG, c, hid, ST_SHR, 0);
          cl_cur[s] = ST_SHR; cl_want[s] = ST_NONE; w_sh--; n_sh++;
        end else if (cl_want[s] == ST_EXC && n_ex == 0 && n_sh == 0) begin
          push_msg(K_UPG, c, hid, ST_EXC, 0);
          cl_cur[s] = ST_EXC; cl_want[s] = ST_NONE; w_ex--; n_ex++;
        end else if (cl_want[s] == ST_EXC && n_ex == 0 && n_sh == 1 && cl_cur[s] == ST_SHR) begin
          push_msg(K_UPG, c, hid, ST_EXC, 0);
          cl_cur[s] = ST_EXC; cl_want[s] = ST_NONE; w_ex--; n_ex++; n_sh--;
        end
      end
    end
    for (int r = 0; r < n; r++) begin
      c = client_at(h, r);
      if (c >= 0) begin
        s = h*NC+c;
        if (w_ex > 0) begin
          if ((cl_cur[s] == ST_SHR || cl_cur[s] == ST_EXC) && srv_want[s] != ST_INV) begin
            push_msg(K_DWN, c, hid, ST_INV, 0);
            srv_want[s] = ST_INV;
          end
        end else if (w_sh > 0) begin
          if (cl_cur[s] == ST_EXC && srv_want[s] != ST_SHR && srv_want[s] != ST_INV) begin
            push_msg(K_DWN, c, hid, ST_SHR, 0);
            srv_want[s] = ST_SHR;
          end
        end
      end
    end
  endfunction

  function automatic int lookup(logic [63:0] id);
    for (int h = 0; h < NH; h++) if (dir_valid[h] && dir_id[h] == id) return h;
    return -1;
  endfunction

  function automatic int lookup_or_alloc(logic [63:0] id);
    int h;
    h = lookup(id);
    if (h >= 0) return h;
    for (h = 0; h < NH; h++)
      if (!dir_valid[h]) begin
        dir_valid[h] = 1'b1;
        dir_id[h] = id;
        for (int c = 0; c < NC; c++) cl_present[h*NC+c] = 1'b0;
        return h;
      end
    return -1;
  endfunction

  function automatic int join_client(int h, int c);
    int s;
    s = h*NC+c;
    if (!cl_present[s]) begin
      cl_rank[s] = clients_of(h);
      cl_present[s] = 1'b1;
      cl_cur[s] = ST_INV; cl_want[s] = ST_NONE; srv_want[s] = ST_NONE;
    end
    return s;
  endfunction

  function automatic void predict_messages(req_t rq);
    int c, h, s;
    st_code_t st;
    bit bad;
    c = rq.client_port;
    st = st_code_t'(rq.req_state);
    bad = (rq.opcode == 2'd3) || (c >= NC)
       || (rq.opcode == OP_UPG && st != ST_SHR && st != ST_EXC)
       || (rq.opcode == OP_DWN && st != ST_INV && st != ST_SHR)
       || (rq.opcode == OP_CLS && st == ST_NONE);
    if (bad) begin
      push_msg(K_ERR, c, rq.handle_id, ST_INV, 1);
      return;
    end
    if (rq.opcode == OP_CLS) begin
      h = lookup(rq.handle_id);
      if (h < 0 || !cl_present[h*NC+c]) begin
        push_msg(K_ERR, c, rq.handle_id, ST_INV, 1);
        return;
      end
      s = h*NC+c;
      push_msg(K_CLS, c, rq.handle_id, 2'd3, 0);
      cl_present[s] = 1'b0;
      shift_ranks(h, cl_rank[s]);
      if (clients_of(h) == 0) dir_valid[h] = 1'b0;
      else arbitrate(h);
    end else begin
      h = lookup_or_alloc(rq.handle_id);
      if (h < 0) begin
        push_msg(K_ERR, c, rq.handle_id, ST_INV, 1);
        return;
      end
      s = join_client(h, c);
      if (rq.opcode == OP_UPG) begin
        if (cl_cur[s] < st) begin
          cl_cur[s] = ST_INV;
          cl_want[s] = st;
          shift_ranks(h, cl_rank[s]);
          cl_rank[s] = clients_of(h) - 1;
          arbitrate(h);
        end
      end else begin
        cl_cur[s] = st;
        if (st <= srv_want[s]) srv_want[s] = ST_NONE;
        arbitrate(h);
      end
    end
    push_msg(K_DONE, c, rq.handle_id, ST_INV, 1);
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void add_req(logic [1:0] op, logic [2:0] cp, logic [63:0] id,
                                  logic [1:0] st);
    req_t r;
    r.opcode = op; r.client_port = cp; r.handle_id = id; r.req_state = st;
    pending_reqs.push_back(r);
  endfunction

  // driver
  int  in_gap = 0;
  bit  hold_drain = 1'b0;
  bit  in_fire = 1'b0;
  req_t cur_req;
  initial begin
    in_chan.valid = 1'b0;
    in_chan.opcode = '0;
    in_chan.client_port = '0;
    in_chan.handle_id = '0;
    in_chan.req_state = '0;
    out_chan.ready = 1'b0;
  end

  // request acceptance is taken at the rising edge
  always @(posedge clk) begin
    in_fire <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      predict_messages(cur_req);
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_chan.valid || in_fire) begin
        if (in_gap > 0 || pending_reqs.size() == 0 || (hold_drain && expected_msgs.size() != 0)
            || (in_fire && $urandom_range(3) == 0)) begin
          in_chan.valid <= 1'b0;
          if (in_fire) in_gap <= gap_len();
          else if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          cur_req = pending_reqs.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.opcode <= cur_req.opcode;
          in_chan.client_port <= cur_req.client_port;
          in_chan.handle_id <= cur_req.handle_id;
          in_chan.req_state <= cur_req.req_state;
        end
      end
    end
  end

  // sink stalls
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_chan.ready <= 1'b0;
      end else if ($urandom_range(4) == 0) begin
        out_gap <= gap_len();
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    msg_t exp_m;
    cycles <= cycles + 1;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_msgs.size() == 0) begin
        $error("unexpected message kind %0d dest %0d", out_chan.msg_kind, out_chan.dest_client);
        fails++;
      end else begin
        exp_m = expected_msgs.pop_front();
        if (out_chan.msg_kind !== exp_m.kind) begin
          $error("msg_kind expected %0d actual %0d", exp_m.kind, out_chan.msg_kind);
          fails++;
        end
        if (out_chan.dest_client !== exp_m.dest) begin
          $error("dest_client expected %0d actual %0d", exp_m.dest, out_chan.dest_client);
          fails++;
        end
        if (out_chan.msg_handle !== exp_m.handle) begin
          $error("msg_handle expected %h actual %h", exp_m.handle, out_chan.msg_handle);
          fails++;
        end
        if (out_chan.msg_state !== exp_m.state) begin
          $error("msg_state expected %0d actual %0d", exp_m.state, out_chan.msg_state);
          fails++;
        end
        if (out_chan.last !== exp_m.last) begin
          $error("last expected %0d actual %0d", exp_m.last, out_chan.last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int op, cp, st, k;
    logic [63:0] id;
    for (int i = 0; i < 6; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = '0;
    id_pool[1] = '1;
    // directed: error cases, extremes, contention
    add_req(2'd3, 3'd0, 64'd5, 2'd1);
    add_req(OP_UPG, 3'd7, '1, ST_INV);
    add_req(OP_UPG, 3'd7, '1, ST_NONE);
    add_req(OP_DWN, 3'd0, '0, ST_EXC);
    add_req(OP_DWN, 3'd0, '0, ST_NONE);
    add_req(OP_CLS, 3'd0, '0, ST_NONE);
    add_req(OP_CLS, 3'd0, 64'h1234, ST_INV);
    add_req(OP_UPG, 3'd0, '0, ST_EXC);
    add_req(OP_UPG, 3'd1, '0, ST_SHR);
    add_req(OP_UPG, 3'd2, '0, ST_EXC);
    add_req(OP_UPG, 3'd0, '0, ST_SHR);
    add_req(OP_DWN, 3'd0, '0, ST_INV);
    add_req(OP_DWN, 3'd1, '0, ST_INV);
    add_req(OP_CLS, 3'd3, '0, ST_INV);
    add_req(OP_UPG, 3'd7, '1, ST_SHR);
    add_req(OP_UPG, 3'd6, '1, ST_SHR);
    add_req(OP_UPG, 3'd7, '1, ST_EXC);
    add_req(OP_CLS, 3'd6, '1, ST_SHR);
    for (int i = 0; i < 16; i++) add_req(OP_UPG, 3'd5, 64'h100 + i, ST_SHR);
    add_req(OP_DWN, 3'd4, 64'hdead, ST_INV);
    for (int i = 0; i < 16; i++) add_req(OP_CLS, 3'd5, 64'h100 + i, ST_INV);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0);
    hold_drain = 1'b1;
    @(posedge clk);
    wait (!in_chan.valid);
    wait (expected_msgs.size() == 0);
    hold_drain = 1'b0;
    for (int i = 0; i < 330; i++) begin
      k = $urandom_range(99);
      id = (k < 90) ? id_pool[$urandom_range(5)] : {$urandom, $urandom};
      cp = $urandom_range(7);
      if (k < 3) begin
        op = 3; st = $urandom_range(3);
      end else if (k < 45) begin
        op = OP_UPG; st = (k < 42) ? $urandom_range(2, 1) : $urandom_range(3);
      end else if (k < 75) begin
        op = OP_DWN; st = (k < 72) ? $urandom_range(1) : $urandom_range(3);
      end else begin
        op = OP_CLS; st = $urandom_range(3);
      end
      add_req(op[1:0], cp[2:0], id, st[1:0]);
      if (i == 160) begin
        wait (pending_reqs.size() == 0);
        hold_drain = 1'b1;
        @(posedge clk);
        wait (!in_chan.valid);
        wait (expected_msgs.size() == 0);
        hold_drain = 1'b0;
      end
    end
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    wait (!in_chan.valid);
    wait (expected_msgs.size() == 0);
    repeat (200) @(posedge clk);
    if (fails == 0 && expected_msgs.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

### sim.f
hdl/sedir_pkg.sv
hdl/sedir_ifs.sv
hdl/sedir_out_stage.sv
hdl/shared_exclusive_directory_server.sv
bench/tb_sedir_ifs.sv
bench/tb_shared_exclusive_directory_server.sv
